// ===== sv/assert_macros.svh =====
// Assertion macros for the RTL files; cbb_datapath.sv includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed: invariant");

// The antecedent in a cycle implies the consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

`endif

// ===== sv/cbb_pkg.sv =====
package cbb_pkg;

   localparam int SAMPLE_W    = 8;
   localparam int BOX_W       = 15;
   localparam int TENT_W      = 22;
   localparam int QUAD_W      = 29;
   localparam int COUNT_W     = 9;
   localparam int RADIUS_W    = 6;
   localparam int ORDER_W     = 2;
   localparam int BOXW_W      = 7;
   localparam int WSQ_W       = 14;
   localparam int DIVISOR_W   = 21;
   localparam int QUOT_W      = 8;
   localparam int DSH_W       = DIVISOR_W + QUOT_W - 1;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;

   localparam int DEFAULT_MAX_RADIUS = 63;
   localparam int RADIUS_CODE_MAX    = 63;

   localparam logic [CSR_INDEX_W-1:0] REG_RADIUS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_ORDER  = 2'd1;

   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 6'd1;
   localparam logic [ORDER_W-1:0]  ORDER_RESET  = 2'd3;

   localparam logic [ORDER_W-1:0] ORDER_OFF  = 2'd0;
   localparam logic [ORDER_W-1:0] ORDER_BOX  = 2'd1;
   localparam logic [ORDER_W-1:0] ORDER_TENT = 2'd2;
   localparam logic [ORDER_W-1:0] ORDER_QUAD = 2'd3;

   typedef struct packed {
      logic load_item;
      logic do_read;
      logic do_box;
      logic do_tent;
      logic do_quad;
      logic div_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic emit;
      logic out_free;
   } status_type;

endpackage

// ===== sv/cascaded_box_blur_line_filter.sv =====
// Cascaded box filter over one line of 8-bit samples.
// Input channel req_*: one sample per beat, req_line_start marks the first
// sample of a line and clears the running sums, the count and the delay
// line position before that sample is taken.
// Output channel rsp_*: one filtered sample per input beat once
// order*2*radius+1 samples of the line have arrived; earlier beats give none.
// Configuration csr_*: index 0 is radius, index 1 is order; csr_ready is
// always high and any write to either register restarts the line. Order 0
// works as order 1. Timing: a sample that gives no result passes through the
// load, read, box, tent and quad steps. One that gives a result also runs
// the restoring divider, which retires one quotient bit per cycle, then the
// output step. The sum stages run in turn, each on its own delay-line memory.
// The result sits in an output register, so the next sample is taken while
// it waits; if the receiver stalls past the next result, the block holds
// that result in its divider and raises req_stall until the register frees.
// Reset restores radius 1 and order 3 and clears the line state; the delay
// lines are not cleared, since every entry is written before it is read.
module cascaded_box_blur_line_filter #(
   parameter int MAX_RADIUS = cbb_pkg::DEFAULT_MAX_RADIUS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [cbb_pkg::SAMPLE_W-1:0]    req_sample,
   input  logic                            req_line_start,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [cbb_pkg::SAMPLE_W-1:0]    rsp_blurred,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [cbb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [cbb_pkg::CSR_DATA_W-1:0]  csr_data
);

   cbb_pkg::cmd_type    cmd;
   cbb_pkg::status_type status;

   assign csr_ready = 1'b1;

   cbb_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   cbb_datapath #(
      .MAX_RADIUS (MAX_RADIUS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_sample     (req_sample),
      .req_line_start (req_line_start),
      .csr_we         (csr_valid && csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_blurred    (rsp_blurred)
   );

endmodule

// ===== sv/cbb_control.sv =====
module cbb_control (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  cbb_pkg::status_type status,
   output cbb_pkg::cmd_type    cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_READ = 3'd1;
   localparam logic [2:0] S_BOX  = 3'd2;
   localparam logic [2:0] S_TENT = 3'd3;
   localparam logic [2:0] S_QUAD = 3'd4;
   localparam logic [2:0] S_DIV  = 3'd5;
   localparam logic [2:0] S_OUT  = 3'd6;

   localparam int CNT_W = $clog2(cbb_pkg::QUOT_W);

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = S_READ;
            end
         end
         S_READ: begin
            cmd.do_read = 1'b1;
            state_in    = S_BOX;
         end
         S_BOX: begin
            cmd.do_box = 1'b1;
            state_in   = S_TENT;
         end
         S_TENT: begin
            cmd.do_tent = 1'b1;
            state_in    = S_QUAD;
         end
         S_QUAD: begin
            cmd.do_quad = 1'b1;
            cnt_in      = '0;
            state_in    = status.emit ? S_DIV : S_IDLE;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(cbb_pkg::QUOT_W - 1)) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// ===== sv/cbb_datapath.sv =====
`include "assert_macros.svh"

module cbb_datapath #(
   parameter int MAX_RADIUS = cbb_pkg::DEFAULT_MAX_RADIUS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  cbb_pkg::cmd_type                   cmd,
   output cbb_pkg::status_type                status,
   input  logic [cbb_pkg::SAMPLE_W-1:0]       req_sample,
   input  logic                               req_line_start,
   input  logic                               csr_we,
   input  logic [cbb_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [cbb_pkg::CSR_DATA_W-1:0]     csr_data,
   input  logic                               rsp_stall,
   output logic                               rsp_valid,
   output logic [cbb_pkg::SAMPLE_W-1:0]       rsp_blurred
);

   localparam int LINE_DEPTH = 2 * MAX_RADIUS + 1;
   localparam int ADDR_W     = $clog2(LINE_DEPTH);
   localparam int CLAMP_R    =
      (MAX_RADIUS < cbb_pkg::RADIUS_CODE_MAX) ? MAX_RADIUS : cbb_pkg::RADIUS_CODE_MAX;

   logic [cbb_pkg::SAMPLE_W-1:0] line_one   [LINE_DEPTH];
   logic [cbb_pkg::BOX_W-1:0]    line_two   [LINE_DEPTH];
   logic [cbb_pkg::TENT_W-1:0]   line_three [LINE_DEPTH];

   logic [cbb_pkg::RADIUS_W-1:0]  radius_ff;
   logic [cbb_pkg::ORDER_W-1:0]   order_ff;
   logic [cbb_pkg::SAMPLE_W-1:0]  x_ff;
   logic [cbb_pkg::SAMPLE_W-1:0]  rd1_ff;
   logic [cbb_pkg::BOX_W-1:0]     rd2_ff;
   logic [cbb_pkg::TENT_W-1:0]    rd3_ff;
   logic [cbb_pkg::BOX_W-1:0]     box_ff, box_in;
   logic [cbb_pkg::TENT_W-1:0]    tent_ff, tent_in;
   logic [cbb_pkg::QUAD_W-1:0]    quad_ff, quad_in;
   logic [cbb_pkg::COUNT_W-1:0]   seen_ff;
   logic [ADDR_W-1:0]             pos_ff, pos_in;
   logic [cbb_pkg::WSQ_W-1:0]     wsq_ff;
   logic [cbb_pkg::DIVISOR_W-1:0] wcube_ff;
   logic [cbb_pkg::DIVISOR_W-1:0] div_ff, divisor;
   logic [cbb_pkg::QUAD_W-1:0]    rem_ff, value;
   logic [cbb_pkg::DSH_W-1:0]     dsh_ff;
   logic [cbb_pkg::QUOT_W-1:0]    quot_ff;
   logic                          rsp_valid_ff;
   logic [cbb_pkg::SAMPLE_W-1:0]  rsp_data_ff;

   logic [cbb_pkg::RADIUS_W-1:0]  r_eff;
   logic [cbb_pkg::BOXW_W-1:0]    w;
   logic [cbb_pkg::ORDER_W-1:0]   k;
   logic [cbb_pkg::COUNT_W-1:0]   t_w1, t_w, t_2w2, t_2w1, t_3w2, t_emit;
   logic                          rem_ge;
   logic                          clear_line;

   assign r_eff = (int'(radius_ff) > CLAMP_R) ? cbb_pkg::RADIUS_W'(CLAMP_R) : radius_ff;
   assign w     = {r_eff, 1'b1};
   assign k     = (order_ff == cbb_pkg::ORDER_OFF) ? cbb_pkg::ORDER_BOX : order_ff;

   // Warm-up thresholds on the sample count, all derived from the radius.
   assign t_w1  = cbb_pkg::COUNT_W'(r_eff) << 1;
   assign t_w   = t_w1 + 1'b1;
   assign t_2w2 = cbb_pkg::COUNT_W'(r_eff) << 2;
   assign t_2w1 = t_2w2 + 1'b1;
   assign t_3w2 = t_2w2 + t_w1 + 1'b1;

   always_comb begin
      case (k)
         cbb_pkg::ORDER_TENT: begin
            t_emit  = t_2w2;
            divisor = cbb_pkg::DIVISOR_W'(wsq_ff);
         end
         cbb_pkg::ORDER_QUAD: begin
            t_emit  = t_3w2 - 1'b1;
            divisor = wcube_ff;
         end
         default: begin
            t_emit  = t_w1;
            divisor = cbb_pkg::DIVISOR_W'(w);
         end
      endcase
   end

   assign box_in = box_ff + cbb_pkg::BOX_W'(x_ff)
                 - ((seen_ff >= t_w) ? cbb_pkg::BOX_W'(rd1_ff) : '0);
   assign tent_in = tent_ff + cbb_pkg::TENT_W'(box_ff)
                  - ((seen_ff >= t_2w1) ? cbb_pkg::TENT_W'(rd2_ff) : '0);
   assign quad_in = quad_ff + cbb_pkg::QUAD_W'(tent_ff)
                  - ((seen_ff >= t_3w2) ? cbb_pkg::QUAD_W'(rd3_ff) : '0);

   // Picks box, tent or quad sum; quad in the same cycle it is formed.
   always_comb begin
      case (k)
         cbb_pkg::ORDER_TENT: value = cbb_pkg::QUAD_W'(tent_ff);
         cbb_pkg::ORDER_QUAD: value = (seen_ff >= t_2w2) ? quad_in : quad_ff;
         default:             value = cbb_pkg::QUAD_W'(box_ff);
      endcase
   end

   always_comb begin
      pos_in = pos_ff + 1'b1;
      if (int'(pos_in) >= int'(w)) begin
         pos_in = '0;
      end
   end

   assign status.emit     = (seen_ff >= t_emit);
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   assign rem_ge = (rem_ff >= cbb_pkg::QUAD_W'(dsh_ff));

   assign clear_line = (cmd.load_item && req_line_start) ||
                       (csr_we && (csr_index == cbb_pkg::REG_RADIUS ||
                                   csr_index == cbb_pkg::REG_ORDER));

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= cbb_pkg::RADIUS_RESET;
         order_ff  <= cbb_pkg::ORDER_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            cbb_pkg::REG_RADIUS: radius_ff <= csr_data[cbb_pkg::RADIUS_W-1:0];
            cbb_pkg::REG_ORDER:  order_ff  <= csr_data[cbb_pkg::ORDER_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear_line) begin
         box_ff  <= '0;
         tent_ff <= '0;
         quad_ff <= '0;
         seen_ff <= '0;
         pos_ff  <= '0;
      end else begin
         if (cmd.do_box) begin
            box_ff <= box_in;
         end
         if (cmd.do_tent && seen_ff >= t_w1) begin
            tent_ff <= tent_in;
         end
         if (cmd.do_quad) begin
            if (seen_ff >= t_2w2) begin
               quad_ff <= quad_in;
            end
            pos_ff <= pos_in;
            if (seen_ff < t_3w2) begin
               seen_ff <= seen_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         x_ff <= req_sample;
      end
      if (cmd.do_read) begin
         rd1_ff <= line_one[pos_ff];
         rd2_ff <= line_two[pos_ff];
         rd3_ff <= line_three[pos_ff];
      end
      if (cmd.do_box) begin
         line_one[pos_ff] <= x_ff;
         wsq_ff           <= cbb_pkg::WSQ_W'(w) * cbb_pkg::WSQ_W'(w);
      end
      if (cmd.do_tent) begin
         if (seen_ff >= t_w1) begin
            line_two[pos_ff] <= box_ff;
         end
         wcube_ff <= cbb_pkg::DIVISOR_W'(wsq_ff) * cbb_pkg::DIVISOR_W'(w);
      end
      if (cmd.do_quad && seen_ff >= t_2w2) begin
         line_three[pos_ff] <= tent_ff;
      end
   end

   // Restoring division, one quotient bit per beat of the sequencer.
   always_ff @(posedge clock) begin
      if (cmd.do_quad) begin
         rem_ff  <= value;
         div_ff  <= divisor;
         dsh_ff  <= cbb_pkg::DSH_W'(divisor) << (cbb_pkg::QUOT_W - 1);
         quot_ff <= '0;
      end else if (cmd.div_step) begin
         if (rem_ge) begin
            rem_ff <= rem_ff - cbb_pkg::QUAD_W'(dsh_ff);
         end
         quot_ff <= {quot_ff[cbb_pkg::QUOT_W-2:0], rem_ge};
         dsh_ff  <= dsh_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff <= quot_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_blurred = rsp_data_ff;

   `ASSERT_ALWAYS(a_pos_in_box, clock, reset, int'(pos_ff) < int'(w))
   `ASSERT_ALWAYS(a_seen_saturates, clock, reset, seen_ff <= t_3w2)
   `ASSERT_IMPLIES(a_load_when_free, clock, reset, cmd.out_load,
                   !rsp_valid_ff || !rsp_stall)
   `ASSERT_IMPLIES(a_div_remainder, clock, reset, cmd.out_load,
                   rem_ff < cbb_pkg::QUAD_W'(div_ff))

endmodule
